FILE: rtl/core/tlbtb_pkg.sv
// ----------------------------------------------------------------------------
// tlbtb_pkg: shared types and constants of the two-level BTB predictor
// Holds field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package tlbtb_pkg;

  localparam int TAG_W      = 30;
  localparam int ADDR_W     = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int STORE_W    = 20;

  // Counter value that every counter holds after reset.
  localparam logic [1:0] RESET_FSM_INIT = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BTB_SIZE_LOG2  = 3'd0,
    CFG_HISTORY_BITS   = 3'd1,
    CFG_TAG_BITS       = 3'd2,
    CFG_FSM_INIT       = 3'd3,
    CFG_GLOBAL_HISTORY = 3'd4,
    CFG_GLOBAL_TABLE   = 3'd5,
    CFG_SHARE_MODE     = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] SHARE_HIST    = 2'd0;
  localparam logic [1:0] SHARE_PC_LOW  = 2'd1;

endpackage
`default_nettype wire

FILE: rtl/core/two_level_btb_branch_predictor.sv
// ----------------------------------------------------------------------------
// two_level_btb_branch_predictor: BTB with a two-level direction predictor
// Direct-mapped target buffer plus 2-bit counters indexed by branch history, optionally XORed with PC bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid / in_stall. A word with in_req_type low is
//   a prediction request for in_pc; a word with in_req_type high reports a
//   resolved branch and trains the entry, counters and history.
//   Every input word produces exactly one result word on out_valid /
//   out_stall, carrying the direction, target, branch and flush counts and
//   the storage size of the current configuration.
//   On accept, the entry and its counter row are read from on-chip memory
//   into registers; once the output register is free, the result is
//   registered and, for an update, the modified entry and row are written
//   back. Due to the read-modify-write of the counter row memory, a new word
//   is not taken before the last one completes; in_stall is high while a word is in flight.
//   If the receiver stalls, the result holds in the output register and the
//   block waits in its read state until the output register is free.
//   Reset (rst_n low, synchronous) clears the entry valid bits, the history,
//   the counts, and marks every counter row as holding the reset counter
//   value; no clearing pass is needed. Configuration writes are taken at any
//   time but are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module two_level_btb_branch_predictor #(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_HISTORY = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tlbtb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tlbtb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_req_type,
  input  wire logic [31:0]                         in_pc,
  input  wire logic [31:0]                         in_target_pc,
  input  wire logic                                in_taken,
  input  wire logic [31:0]                         in_predicted_dest,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_predict_taken,
  output logic [31:0]                              out_predicted_target,
  output logic [31:0]                              out_branch_count,
  output logic [31:0]                              out_flush_count,
  output logic [tlbtb_pkg::STORE_W-1:0]            out_storage_bits
);

  localparam int LOG_MAX = $clog2(MAX_ENTRIES);
  localparam int IDXW    = (LOG_MAX > 0) ? LOG_MAX : 1;
  localparam int HP      = 1 << MAX_HISTORY;
  localparam int ROW_W   = 2 * HP;
  localparam int TW      = tlbtb_pkg::TAG_W;
  localparam int ENT_W   = TW + 32 + MAX_HISTORY;
  localparam int SW      = tlbtb_pkg::STORE_W;

  typedef enum logic {S_IDLE, S_RD} state_t;

  // Configuration registers.
  logic [2:0] btb_size_log2_r;
  logic [3:0] history_bits_r;
  logic [4:0] tag_bits_r;
  logic [1:0] fsm_init_r;
  logic       global_history_r, global_table_r;
  logic [1:0] share_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btb_size_log2_r  <= 3'd0;
      history_bits_r   <= 4'd1;
      tag_bits_r       <= 5'd0;
      fsm_init_r       <= tlbtb_pkg::RESET_FSM_INIT;
      global_history_r <= 1'b0;
      global_table_r   <= 1'b0;
      share_mode_r     <= tlbtb_pkg::SHARE_HIST;
    end else if (cfg_we) begin
      case (tlbtb_pkg::cfg_idx_t'(cfg_index))
        tlbtb_pkg::CFG_BTB_SIZE_LOG2:  btb_size_log2_r  <= cfg_data[2:0];
        tlbtb_pkg::CFG_HISTORY_BITS:   history_bits_r   <= cfg_data[3:0];
        tlbtb_pkg::CFG_TAG_BITS:       tag_bits_r       <= cfg_data[4:0];
        tlbtb_pkg::CFG_FSM_INIT:       fsm_init_r       <= cfg_data[1:0];
        tlbtb_pkg::CFG_GLOBAL_HISTORY: global_history_r <= cfg_data[0];
        tlbtb_pkg::CFG_GLOBAL_TABLE:   global_table_r   <= cfg_data[0];
        tlbtb_pkg::CFG_SHARE_MODE:     share_mode_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective (saturated) configuration values.
  logic [2:0] elg;
  logic [3:0] ehist;
  logic [4:0] etag;
  logic [MAX_HISTORY-1:0] hmask;
  logic [TW-1:0] tmask;
  logic [IDXW-1:0] imask;

  assign elg   = (btb_size_log2_r > 3'(LOG_MAX)) ? 3'(LOG_MAX) : btb_size_log2_r;
  assign ehist = (history_bits_r > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : history_bits_r;
  assign etag  = (tag_bits_r > 5'(TW)) ? 5'(TW) : tag_bits_r;
  assign hmask = ~({MAX_HISTORY{1'b1}} << ehist);
  assign tmask = ~({TW{1'b1}} << etag);
  assign imask = ~({IDXW{1'b1}} << elg);

  // Storage size; entry counts are powers of two, so products are shifts.
  logic [SW-1:0] st_base, st_hp2, st_h, storage;
  assign st_base = SW'(6'd31 + 6'(etag));
  assign st_hp2  = SW'(2) << ehist;
  assign st_h    = SW'(ehist);
  always_comb begin
    if (global_table_r) begin
      if (global_history_r) storage = (st_base << elg) + st_hp2 + st_h;
      else                  storage = st_hp2 + ((st_base + st_h) << elg);
    end else begin
      if (global_history_r) storage = st_h + ((st_base + st_hp2) << elg);
      else                  storage = (st_base + st_hp2 + st_h) << elg;
    end
  end

  state_t state_r;
  logic   accept, done;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state_r == S_RD) && (!out_valid || !out_stall);

  // Word latched at accept.
  logic            upd_r, tk_r;
  logic [31:0]     pc_r, tgt_r, pdst_r;
  logic [IDXW-1:0] idx_r, row_r, idx_a, row_a;
  logic            val_r, rok_r;

  assign idx_a = in_pc[2 +: IDXW] & imask;
  assign row_a = global_table_r ? '0 : idx_a;

  // Entry memory {tag, target, history} with valid bits in flops.
  logic [ENT_W-1:0] ent_mem [MAX_ENTRIES];
  logic [ENT_W-1:0] ent_q, ent_wd;
  logic [MAX_ENTRIES-1:0] ent_v_r;
  // Counter row memory; a row not yet written reads as reset counters.
  logic [ROW_W-1:0] row_mem [MAX_ENTRIES];
  logic [ROW_W-1:0] row_q, row_wd;
  logic [MAX_ENTRIES-1:0] row_ok_r;

  always_ff @(posedge clk) begin
    if (accept) ent_q <= ent_mem[idx_a];
    if (done && upd_r) ent_mem[idx_r] <= ent_wd;
  end

  always_ff @(posedge clk) begin
    if (accept) row_q <= row_mem[row_a];
    if (done && upd_r) row_mem[row_r] <= row_wd;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd_r  <= in_req_type;
      tk_r   <= in_taken;
      pc_r   <= in_pc;
      tgt_r  <= in_target_pc;
      pdst_r <= in_predicted_dest;
      idx_r  <= idx_a;
      row_r  <= row_a;
      val_r  <= ent_v_r[idx_a];
      rok_r  <= row_ok_r[row_a];
    end
  end

  // Read state: hit check, counter select and training.
  logic [TW-1:0]          tag_cur, ent_tag;
  logic [31:0]            ent_tgt, pc4, tag_sh;
  logic [MAX_HISTORY-1:0] ent_hist, hist_old, hist_use, hist_new, ci, sh_term;
  logic                   hit, refill, flush, pt;
  logic [ROW_W-1:0]       row_cur;
  logic [1:0]             ctr, ctr_new;
  logic [MAX_HISTORY-1:0] shared_hist_r;

  assign tag_sh   = pc_r >> (6'd2 + 6'(elg));
  assign tag_cur  = tag_sh[TW-1:0] & tmask;
  assign ent_tag  = ent_q[ENT_W-1 -: TW];
  assign ent_tgt  = ent_q[MAX_HISTORY +: 32];
  assign ent_hist = val_r ? ent_q[MAX_HISTORY-1:0] : '0;
  assign hit      = val_r && (ent_tag == tag_cur);
  assign pc4      = pc_r + 32'd4;
  assign refill   = upd_r && !hit && !global_table_r;

  always_comb begin
    hist_old = global_history_r ? shared_hist_r : ent_hist;
    // A miss on an update starts a per-entry history from zero.
    hist_use = (upd_r && !hit && !global_history_r) ? '0 : hist_old;
    if (!global_table_r || share_mode_r == tlbtb_pkg::SHARE_HIST) sh_term = '0;
    else if (share_mode_r == tlbtb_pkg::SHARE_PC_LOW) sh_term = pc_r[2 +: MAX_HISTORY];
    else sh_term = pc_r[16 +: MAX_HISTORY];
    ci = (hist_use ^ sh_term) & hmask;
    if (refill)      row_cur = {HP{fsm_init_r}};
    else if (!rok_r) row_cur = {HP{tlbtb_pkg::RESET_FSM_INIT}};
    else             row_cur = row_q;
    ctr = row_cur[2*ci +: 2];
    if (tk_r) ctr_new = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    else      ctr_new = (ctr == 2'd0) ? ctr : ctr - 2'd1;
    for (int i = 0; i < HP; i++) begin
      row_wd[2*i +: 2] = (ci == MAX_HISTORY'(i)) ? ctr_new : row_cur[2*i +: 2];
    end
    hist_new = ((hist_use << 1) | MAX_HISTORY'(tk_r)) & hmask;
    ent_wd   = {tag_cur, tgt_r, global_history_r ? ent_hist : hist_new};
    if (!hit) flush = tk_r;
    else      flush = tk_r ? (pdst_r != tgt_r) : (pdst_r != pc4);
    pt = hit && ctr[1];
  end

  logic [31:0] branches_r, flushes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid     <= 1'b0;
      ent_v_r       <= '0;
      row_ok_r      <= '0;
      shared_hist_r <= '0;
      branches_r    <= '0;
      flushes_r     <= '0;
    end else begin
      // A completing word refills the output register as the old one leaves.
      if (done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_RD;
        end
        S_RD: begin
          if (done) begin
            state_r <= S_IDLE;
            if (upd_r) begin
              ent_v_r[idx_r]  <= 1'b1;
              row_ok_r[row_r] <= 1'b1;
              if (global_history_r) shared_hist_r <= hist_new;
              branches_r <= branches_r + 32'd1;
              if (flush) flushes_r <= flushes_r + 32'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result payload, loaded as the word completes.
  always_ff @(posedge clk) begin
    if (done) begin
      out_predict_taken    <= upd_r ? 1'b0 : pt;
      out_predicted_target <= upd_r ? 32'd0 : (pt ? ent_tgt : pc4);
      out_branch_count     <= upd_r ? branches_r + 32'd1 : branches_r;
      out_flush_count      <= (upd_r && flush) ? flushes_r + 32'd1 : flushes_r;
      out_storage_bits     <= storage;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tlbtb_checker.sv
// ----------------------------------------------------------------------------
// tlbtb_checker: port-level checks of the two-level BTB predictor
// Watches handshakes and results at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none
module tlbtb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_predict_taken,
  input wire logic [31:0] out_predicted_target
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted_target))
    else $error("stalled result word changed");

  // Only one word is in flight: after an accept the input is stalled.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in flight");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The direction bit holds while the result word is stalled.
  a_dir_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_predict_taken))
    else $error("stalled direction bit changed");

endmodule

bind two_level_btb_branch_predictor tlbtb_checker u_tlbtb_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_predict_taken    (out_predict_taken),
  .out_predicted_target (out_predicted_target)
);
`default_nettype wire
